// ===== hw/rtl/tvp_pkg.sv =====
// shared types, step codes and constants of the trapezoid velocity profile unit
`timescale 1ns / 1ps
package tvp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_IDX_W     = 3;
   localparam int STEP_W        = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXVEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK   = 3'd6;

   // controller states, also the datapath step codes
   localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] ST_DISPATCH = 5'd1;
   localparam logic [STEP_W-1:0] ST_START    = 5'd2;
   localparam logic [STEP_W-1:0] ST_DELTA    = 5'd3;
   localparam logic [STEP_W-1:0] ST_SQX      = 5'd4;
   localparam logic [STEP_W-1:0] ST_SQY      = 5'd5;
   localparam logic [STEP_W-1:0] ST_SUM      = 5'd6;
   localparam logic [STEP_W-1:0] ST_ROOTGO   = 5'd7;
   localparam logic [STEP_W-1:0] ST_ROOTW    = 5'd8;
   localparam logic [STEP_W-1:0] ST_TRAV     = 5'd9;
   localparam logic [STEP_W-1:0] ST_DIST     = 5'd10;
   localparam logic [STEP_W-1:0] ST_DECIDE   = 5'd11;
   localparam logic [STEP_W-1:0] ST_BR1      = 5'd12;
   localparam logic [STEP_W-1:0] ST_BR2      = 5'd13;
   localparam logic [STEP_W-1:0] ST_BR3      = 5'd14;
   localparam logic [STEP_W-1:0] ST_BR4      = 5'd15;
   localparam logic [STEP_W-1:0] ST_RAMP     = 5'd16;
   localparam logic [STEP_W-1:0] ST_DONE     = 5'd17;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              load;
      logic              push;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic sqrt_done;
      logic near_goal;
      logic hold;
   } status_type;

endpackage

// ===== hw/rtl/tvp_sqrt.sv =====
// bit-pair integer square root of a 64-bit value, one result bit per cycle
`timescale 1ns / 1ps
module tvp_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] operand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] v_ff, v_in;
   logic [63:0] r_ff, r_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] bit_val;

   always_comb begin
      bit_val = 64'd1 << {cnt_ff, 1'b0};
      trial   = {1'b0, r_ff} + {1'b0, bit_val};
      v_in    = v_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (go) begin
         v_in    = operand;
         r_in    = '0;
         cnt_in  = 5'd31;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in = v_ff - trial[63:0];
            r_in = (r_ff >> 1) + bit_val;
         end else begin
            r_in = r_ff >> 1;
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule

// ===== hw/rtl/tvp_datapath.sv =====
// datapath: settings, move state, shared multiplier, square root and result
`timescale 1ns / 1ps
module tvp_datapath #(
   parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tvp_pkg::cmd_type                  cmd,
   output tvp_pkg::status_type               status,
   input  logic                              in_op,
   input  logic [31:0]                       in_pos_x,
   input  logic [31:0]                       in_pos_y,
   input  logic [30:0]                       in_target_dist,
   input  logic [31:0]                       in_measured_vel,
   input  logic                              csr_we,
   input  logic [tvp_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [30:0]                       csr_val,
   output logic [31:0]                       res_target_vel,
   output logic [31:0]                       res_accel_cmd,
   output logic [30:0]                       res_remaining_dist
);
   import tvp_pkg::*;

   localparam logic [30:0] M31 = 31'h7FFF_FFFF;

   logic [30:0] accel_ff, maxvel_ff, decel_ff, fvel_ff, buf_ff, goal_ff, tick_ff;
   logic        op_ff;
   logic [31:0] px_ff, py_ff, mvel_ff;
   logic [30:0] tdist_ff;
   logic [31:0] sx_ff, sy_ff;
   logic [30:0] mlen_ff;
   logic [31:0] ramp_ff;
   logic        flag_ff;
   logic [30:0] ax_ff, ay_ff;
   logic        far_ff;
   logic [61:0] prod_ff;
   logic [63:0] sum_ff;
   logic [32:0] trav_ff;
   logic [30:0] dist_ff;
   logic [61:0] inc_ff;
   logic [31:0] tv_ff, acc_ff;
   logic [30:0] rd_ff;

   logic [30:0] mul_a, mul_b;
   logic [32:0] dx, dy, adx, ady;
   logic [32:0] diff;
   logic        over;
   logic [62:0] vel;
   logic [32:0] amv;
   logic [31:0] tv_mag;
   logic        go;
   logic [31:0] root;
   logic        sq_done;

   tvp_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .operand (sum_ff),
      .done    (sq_done),
      .root    (root)
   );

   assign go = (cmd.step == ST_ROOTGO) || (cmd.step == ST_BR3);

   always_comb begin
      dx   = {px_ff[31], px_ff} - {sx_ff[31], sx_ff};
      dy   = {py_ff[31], py_ff} - {sy_ff[31], sy_ff};
      adx  = dx[32] ? (33'd0 - dx) : dx;
      ady  = dy[32] ? (33'd0 - dy) : dy;
      over = trav_ff > {2'b00, mlen_ff};
      diff = over ? (trav_ff - {2'b00, mlen_ff}) : ({2'b00, mlen_ff} - trav_ff);
      vel  = {31'd0, ramp_ff} + {1'b0, inc_ff};
      amv  = mvel_ff[31] ? (33'd0 - {1'b1, mvel_ff}) : {1'b0, mvel_ff};
      case (cmd.step)
         ST_SQX:    begin mul_a = ax_ff;   mul_b = ax_ff;   end
         ST_SQY:    begin mul_a = ay_ff;   mul_b = ay_ff;   end
         ST_DECIDE: begin mul_a = decel_ff; mul_b = dist_ff - buf_ff; end
         ST_BR1:    begin mul_a = fvel_ff; mul_b = fvel_ff; end
         default:   begin mul_a = accel_ff; mul_b = tick_ff; end
      endcase
   end

   // ramp limit of the braking curve and of the cruise speed
   logic [62:0] vel_sel;
   logic [31:0] acc_sel;
   logic        set_flag;
   always_comb begin
      vel_sel  = vel;
      acc_sel  = {1'b0, accel_ff};
      set_flag = 1'b0;
      if ({31'd0, root} < vel) begin
         vel_sel  = {31'd0, root};
         acc_sel  = 32'd0 - {1'b0, decel_ff};
         set_flag = amv <= {2'b00, fvel_ff};
      end else if (vel > {32'd0, maxvel_ff}) begin
         vel_sel = {32'd0, maxvel_ff};
         acc_sel = '0;
      end
      tv_mag = (vel_sel > {32'd0, M31}) ? {1'b0, M31} : vel_sel[31:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= 62'(mul_a * mul_b);
      if (cmd.load) begin
         op_ff    <= in_op;
         px_ff    <= in_pos_x;
         py_ff    <= in_pos_y;
         tdist_ff <= in_target_dist;
         mvel_ff  <= in_measured_vel;
      end
      case (cmd.step)
         ST_START: begin
            tv_ff <= '0;
            acc_ff <= '0;
            rd_ff  <= M31;
         end
         ST_DELTA: begin
            ax_ff  <= adx[30:0];
            ay_ff  <= ady[30:0];
            far_ff <= adx[32] | adx[31] | ady[32] | ady[31];
         end
         ST_SQY:  sum_ff <= {2'b00, prod_ff};
         ST_SUM:  sum_ff <= sum_ff + {2'b00, prod_ff};
         ST_TRAV: trav_ff <= far_ff ? 33'h1_0000_0000 : {1'b0, root};
         ST_DIST: dist_ff <= (diff > {2'b00, M31}) ? M31 : diff[30:0];
         ST_DECIDE: begin
            rd_ff <= dist_ff;
            if (status.near_goal) begin
               tv_ff  <= '0;
               acc_ff <= '0;
            end else if (status.hold) begin
               tv_ff  <= over ? (32'd0 - {1'b0, fvel_ff}) : {1'b0, fvel_ff};
               acc_ff <= '0;
            end
         end
         ST_BR1: sum_ff <= {1'b0, prod_ff, 1'b0};
         ST_BR2: sum_ff <= sum_ff + {2'b00, prod_ff};
         ST_BR3: inc_ff <= prod_ff >> FRAC_BITS;
         ST_RAMP: begin
            tv_ff  <= over ? (32'd0 - tv_mag) : tv_mag;
            acc_ff <= over ? (32'd0 - acc_sel) : acc_sel;
         end
         default: ;
      endcase
      if (reset) begin
         accel_ff  <= 31'd10486;
         maxvel_ff <= 31'd65536;
         decel_ff  <= 31'd5243;
         fvel_ff   <= '0;
         buf_ff    <= '0;
         goal_ff   <= '0;
         tick_ff   <= 31'd655;
         sx_ff     <= '0;
         sy_ff     <= '0;
         mlen_ff   <= '0;
         ramp_ff   <= '0;
         flag_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               CSR_ACCEL:  accel_ff  <= csr_val;
               CSR_MAXVEL: maxvel_ff <= csr_val;
               CSR_DECEL:  decel_ff  <= csr_val;
               CSR_FINAL:  fvel_ff   <= csr_val;
               CSR_BUFFER: buf_ff    <= csr_val;
               CSR_GOAL:   goal_ff   <= csr_val;
               CSR_TICK:   tick_ff   <= csr_val;
               default: ;
            endcase
         end
         if (cmd.step == ST_START) begin
            sx_ff   <= px_ff;
            sy_ff   <= py_ff;
            mlen_ff <= tdist_ff;
            ramp_ff <= '0;
            flag_ff <= 1'b0;
         end else if (cmd.step == ST_RAMP) begin
            ramp_ff <= vel_sel[31:0];
            if (set_flag) flag_ff <= 1'b1;
         end
      end
   end

   assign status.is_start  = ~op_ff;
   assign status.sqrt_done = sq_done;
   assign status.near_goal = dist_ff < goal_ff;
   assign status.hold      = (dist_ff < buf_ff) | flag_ff;

   assign res_target_vel     = tv_ff;
   assign res_accel_cmd      = acc_ff;
   assign res_remaining_dist = rd_ff;
endmodule

// ===== hw/rtl/tvp_ctrl.sv =====
// controller state machine sequencing one item through the datapath
`timescale 1ns / 1ps
module tvp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                out_free,
   input  tvp_pkg::status_type status,
   output tvp_pkg::cmd_type    cmd
);
   import tvp_pkg::*;

   logic [STEP_W-1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      in_ready = (state_ff == ST_IDLE);
      cmd.step = state_ff;
      cmd.load = in_ready & in_valid;
      cmd.push = (state_ff == ST_DONE) & out_free;
      case (state_ff)
         ST_IDLE:     if (in_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = status.is_start ? ST_START : ST_DELTA;
         ST_START:    state_in = ST_DONE;
         ST_DELTA:    state_in = ST_SQX;
         ST_SQX:      state_in = ST_SQY;
         ST_SQY:      state_in = ST_SUM;
         ST_SUM:      state_in = ST_ROOTGO;
         ST_ROOTGO:   state_in = ST_ROOTW;
         ST_ROOTW:    if (status.sqrt_done) state_in = ST_TRAV;
         ST_TRAV:     state_in = ST_DIST;
         ST_DIST:     state_in = ST_DECIDE;
         ST_DECIDE:   state_in = (status.near_goal | status.hold) ? ST_DONE : ST_BR1;
         ST_BR1:      state_in = ST_BR2;
         ST_BR2:      state_in = ST_BR3;
         ST_BR3:      state_in = ST_BR4;
         ST_BR4:      if (status.sqrt_done) state_in = ST_RAMP;
         ST_RAMP:     state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== hw/rtl/trapezoid_velocity_profile_unit.sv =====
// top level of the trapezoid velocity profile unit with its result register
`timescale 1ns / 1ps
// sequence: a start item passes DISPATCH and START to DONE; a tick item passes DELTA, SQX,
//   SQY, SUM and a square root to DECIDE, then DONE, or BR1 to BR4 with a second root and RAMP
// throughput: one item at a time; the next is taken once the result is pushed into
//   the output register, and DONE waits while that register holds an untaken result
// reset: synchronous; registers return to their defaults, move state clears
module trapezoid_velocity_profile_unit #(
   parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [127:0]                  req_tdata,  // pos_x, pos_y, target_dist, measured_vel
   input  logic                          req_tuser,  // op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [95:0]                   rsp_tdata,  // target_vel, accel_cmd, remaining_dist
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tvp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [30:0]                   csr_data
);
   import tvp_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic [31:0] r_tv, r_acc;
   logic [30:0] r_rd;
   logic        out_free;

   // result register frees on a take in the same cycle
   assign out_free  = ~rsp_valid_ff | rsp_tready;
   assign csr_ready = 1'b1;

   tvp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .out_free (out_free),
      .status   (status),
      .cmd      (cmd)
   );

   tvp_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .in_op              (req_tuser),
      .in_pos_x           (req_tdata[31:0]),
      .in_pos_y           (req_tdata[63:32]),
      .in_target_dist     (req_tdata[94:64]),
      .in_measured_vel    (req_tdata[126:95]),
      .csr_we             (csr_valid),
      .csr_idx            (csr_index),
      .csr_val            (csr_data),
      .res_target_vel     (r_tv),
      .res_accel_cmd      (r_acc),
      .res_remaining_dist (r_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.push) rsp_data_ff <= {1'b0, r_rd, r_acc, r_tv};
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
